// ===== design/smm_pkg.sv =====
// shared types, widths and sequencer states for the frame statistics unit
`timescale 1ns / 1ps
`default_nettype none

package smm_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int COUNT_W       = 17;
  localparam int SQUARE_W      = 2 * SAMPLE_W - 1;
  localparam int SUM_W         = 33;
  localparam int SQSUM_W       = 47;
  localparam int WIDE_W        = 64;
  localparam int SMAG_W        = 32;
  localparam int RAD_W         = 32;
  localparam int ROOT_W        = 16;
  localparam int REM_W         = 20;
  localparam int STEP_W        = 7;
  localparam int MAX_FRAME_LEN = 65536;

  localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(MAX_FRAME_LEN - 1);

  // iteration counts of the sequencer phases
  localparam int MEAN_STEPS  = SMAG_W;
  localparam int MUL_Q_STEPS = COUNT_W;
  localparam int MUL_S_STEPS = SMAG_W;
  localparam int DIV_STEPS   = WIDE_W;
  localparam int SQRT_STEPS  = ROOT_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABS,
    ST_MEAN,
    ST_MEAN_FIX,
    ST_MUL_Q,
    ST_MUL_S,
    ST_DIV1,
    ST_DIV2,
    ST_SQRT,
    ST_DONE
  } smm_state_t;

  typedef struct packed {
    logic [WIDE_W-1:0] a;
    logic [WIDE_W-1:0] b;
    logic              sub;
  } smm_alu_req_t;

  typedef struct packed {
    logic [WIDE_W-1:0] sum;
    logic              carry;
  } smm_alu_rsp_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  cnt;
    logic [SAMPLE_W-1:0] min_val;
    logic [SAMPLE_W-1:0] max_val;
    logic [SUM_W-1:0]    sum;
    logic [SQSUM_W-1:0]  sqsum;
  } smm_frame_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  cnt;
    logic [SAMPLE_W-1:0] min_val;
    logic [SAMPLE_W-1:0] max_val;
    logic [SAMPLE_W-1:0] mean_val;
    logic [ROOT_W-1:0]   std_val;
  } smm_result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } smm_status_t;

endpackage

`default_nettype wire

// ===== design/smm_addsub.sv =====
// shared 64-bit adder / subtractor with carry out (carry set on subtract means a >= b)
`timescale 1ns / 1ps
`default_nettype none

module smm_addsub
  import smm_pkg::*;
(
  input  smm_alu_req_t req,
  output smm_alu_rsp_t rsp
);

  logic [WIDE_W:0] total;

  assign total = {1'b0, req.a} + {1'b0, req.b ^ {WIDE_W{req.sub}}} + (WIDE_W + 1)'(req.sub);

  assign rsp.sum   = total[WIDE_W-1:0];
  assign rsp.carry = total[WIDE_W];

endmodule

`default_nettype wire

// ===== design/smm_post.sv =====
// end-of-frame sequencer: mean, variance and square root on the shared adder
`timescale 1ns / 1ps
`default_nettype none

module smm_post
  import smm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  smm_frame_t  frame,
  input  logic        take,
  output smm_status_t status,
  output smm_result_t result
);

  smm_state_t state;
  smm_state_t state_next;

  logic [COUNT_W-1:0]  n_reg;
  logic [SAMPLE_W-1:0] min_reg;
  logic [SAMPLE_W-1:0] max_reg;
  logic [SUM_W-1:0]    sum_reg;
  logic [SQSUM_W-1:0]  sqsum_reg;
  logic [SMAG_W-1:0]   smag;
  logic [SAMPLE_W-1:0] mean;
  logic [WIDE_W-1:0]   acc;
  logic [WIDE_W-1:0]   opnd;
  logic [SMAG_W-1:0]   mbits;
  logic [REM_W-1:0]    rem;
  logic [ROOT_W-1:0]   root;
  logic [STEP_W-1:0]   step;

  logic                last_step;
  logic [COUNT_W:0]    rs_div;
  logic [REM_W-1:0]    rs_sq;
  smm_alu_req_t        alu_req;
  smm_alu_rsp_t        alu_rsp;

  smm_addsub u_addsub (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign last_step = (step == '0);
  // restoring divide: next dividend bit into the partial remainder
  assign rs_div = {rem[COUNT_W-1:0], acc[WIDE_W-1]};
  // digit-by-digit root: two radicand bits a step
  assign rs_sq  = {rem[REM_W-3:0], acc[RAD_W-1 -: 2]};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (start) state_next = ST_ABS;
      ST_ABS:      state_next = ST_MEAN;
      ST_MEAN:     if (last_step) state_next = ST_MEAN_FIX;
      ST_MEAN_FIX: state_next = ST_MUL_Q;
      ST_MUL_Q:    if (last_step) state_next = ST_MUL_S;
      ST_MUL_S:    if (last_step) state_next = ST_DIV1;
      ST_DIV1:     if (last_step) state_next = ST_DIV2;
      ST_DIV2:     if (last_step) state_next = ST_SQRT;
      ST_SQRT:     if (last_step) state_next = ST_DONE;
      ST_DONE:     if (take) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // shared unit operands
  always_comb begin
    alu_req = '0;
    unique case (state)
      ST_ABS: begin
        alu_req.b   = {{(WIDE_W - SUM_W){sum_reg[SUM_W-1]}}, sum_reg};
        alu_req.sub = sum_reg[SUM_W-1];
      end
      ST_MEAN, ST_DIV1, ST_DIV2: begin
        alu_req.a   = WIDE_W'(rs_div);
        alu_req.b   = WIDE_W'(n_reg);
        alu_req.sub = 1'b1;
      end
      ST_MEAN_FIX: begin
        alu_req.b   = WIDE_W'(acc[SMAG_W-1:0]);
        alu_req.sub = sum_reg[SUM_W-1];
      end
      ST_MUL_Q: begin
        alu_req.a   = acc;
        alu_req.b   = opnd;
      end
      ST_MUL_S: begin
        alu_req.a   = acc;
        alu_req.b   = opnd;
        alu_req.sub = 1'b1;
      end
      ST_SQRT: begin
        alu_req.a   = WIDE_W'(rs_sq);
        alu_req.b   = WIDE_W'({root, 2'b01});
        alu_req.sub = 1'b1;
      end
      ST_IDLE, ST_DONE: alu_req = '0;
      default: alu_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (state != ST_IDLE && state != ST_DONE && state != ST_ABS
                 && state != ST_MEAN_FIX) begin
      if (!last_step) begin
        step <= step - STEP_W'(1);
      end else begin
        priority case (state)
          ST_MUL_Q: step <= STEP_W'(MUL_S_STEPS - 1);
          ST_MUL_S: step <= STEP_W'(DIV_STEPS - 1);
          ST_DIV1:  step <= STEP_W'(DIV_STEPS - 1);
          ST_DIV2:  step <= STEP_W'(SQRT_STEPS - 1);
          default:  step <= '0;
        endcase
      end
    end else if (state == ST_ABS) begin
      step <= STEP_W'(MEAN_STEPS - 1);
    end else if (state == ST_MEAN_FIX) begin
      step <= STEP_W'(MUL_Q_STEPS - 1);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          n_reg     <= frame.cnt;
          min_reg   <= frame.min_val;
          max_reg   <= frame.max_val;
          sum_reg   <= frame.sum;
          sqsum_reg <= frame.sqsum;
        end
      end
      ST_ABS: begin
        smag <= alu_rsp.sum[SMAG_W-1:0];
        acc  <= {alu_rsp.sum[SMAG_W-1:0], {(WIDE_W - SMAG_W){1'b0}}};
        rem  <= '0;
      end
      ST_MEAN, ST_DIV1, ST_DIV2: begin
        acc <= {acc[WIDE_W-2:0], alu_rsp.carry};
        if (last_step) begin
          rem  <= '0;
          root <= '0;
        end else begin
          rem <= alu_rsp.carry ? alu_rsp.sum[REM_W-1:0] : REM_W'(rs_div);
        end
      end
      ST_MEAN_FIX: begin
        mean  <= alu_rsp.sum[SAMPLE_W-1:0];
        acc   <= '0;
        opnd  <= WIDE_W'(sqsum_reg);
        mbits <= SMAG_W'(n_reg);
      end
      ST_MUL_Q, ST_MUL_S: begin
        if (mbits[0]) acc <= alu_rsp.sum;
        if (last_step && state == ST_MUL_Q) begin
          opnd  <= WIDE_W'(smag);
          mbits <= smag;
        end else begin
          opnd  <= {opnd[WIDE_W-2:0], 1'b0};
          mbits <= {1'b0, mbits[SMAG_W-1:1]};
        end
        if (last_step && state == ST_MUL_S) begin
          rem <= '0;
        end
      end
      ST_SQRT: begin
        acc  <= {acc[WIDE_W-3:0], 2'b00};
        rem  <= alu_rsp.carry ? alu_rsp.sum[REM_W-1:0] : rs_sq;
        root <= {root[ROOT_W-2:0], alu_rsp.carry};
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign status.busy = (state != ST_IDLE);
  assign status.done = (state == ST_DONE);

  assign result.cnt      = n_reg;
  assign result.min_val  = min_reg;
  assign result.max_val  = max_reg;
  assign result.mean_val = mean;
  assign result.std_val  = root;

endmodule

`default_nettype wire

// ===== design/stream_min_max_mean_stddev_unit.sv =====
// top level of the streaming frame statistics unit (min, max, mean, std deviation)
//
// input channel: sample (signed Q2.13) and frame_end move on a sample_valid / sample_stall
// beat. output channel: one beat per frame with sample_count, min_value, max_value,
// mean_value and std_value on result_valid / result_stall.
// samples that do not close a frame are taken one per cycle; a registered squarer feeds
// the accumulators in the next cycle. a frame closes on frame_end or on the sample
// that brings the count to 65536.
// the closing sample starts the end-of-frame sequencer, which runs the mean divide, the
// n*sumsq - sum^2 shift-add products, two divides by n and the square root, all on one
// shared 64-bit adder. sample_stall stays high while it runs, through the 64-step divides
// and the other passes of that adder, until its result is taken into the output register.
// the finished result waits in an output register; the next frame may stream in while
// the receiver holds result_stall, and the sequencer holds its answer until that
// register frees up.
// rst (synchronous) empties the pipeline, clears the accumulators and drops result_valid.
`timescale 1ns / 1ps
`default_nettype none

module stream_min_max_mean_stddev_unit
  import smm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                frame_end,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [COUNT_W-1:0]  sample_count,
  output logic [SAMPLE_W-1:0] min_value,
  output logic [SAMPLE_W-1:0] max_value,
  output logic [SAMPLE_W-1:0] mean_value,
  output logic [ROOT_W-1:0]   std_value
);

  // squaring stage
  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic [SQUARE_W-1:0] s1_square;
  logic                s1_frame_end;

  // running accumulators
  logic [COUNT_W-1:0]  count_so_far;
  logic [SAMPLE_W-1:0] running_min;
  logic [SAMPLE_W-1:0] running_max;
  logic [SUM_W-1:0]    running_sum;
  logic [SQSUM_W-1:0]  running_square_sum;

  logic                accept;
  logic                frame_done;
  logic [2*SAMPLE_W-1:0] product;
  smm_frame_t          frame_upd;
  smm_status_t         post_status;
  smm_result_t         post_result;
  smm_result_t         res_reg;
  logic                load_out;

  assign accept  = sample_valid && !sample_stall;
  assign product = $signed(sample) * $signed(sample);

  // closing sample sits in the squaring stage
  assign frame_done   = s1_valid && (s1_frame_end || count_so_far == COUNT_LAST);
  assign sample_stall = post_status.busy || frame_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample    <= sample;
      s1_square    <= product[SQUARE_W-1:0];
      s1_frame_end <= frame_end;
    end
  end

  // accumulator update; first sample of a frame seeds min and max
  always_comb begin
    frame_upd.cnt = count_so_far + COUNT_W'(1);
    if (count_so_far == '0 || $signed(s1_sample) < $signed(running_min)) begin
      frame_upd.min_val = s1_sample;
    end else begin
      frame_upd.min_val = running_min;
    end
    if (count_so_far == '0 || $signed(s1_sample) > $signed(running_max)) begin
      frame_upd.max_val = s1_sample;
    end else begin
      frame_upd.max_val = running_max;
    end
    frame_upd.sum   = running_sum + {{(SUM_W - SAMPLE_W){s1_sample[SAMPLE_W-1]}}, s1_sample};
    frame_upd.sqsum = running_square_sum + SQSUM_W'(s1_square);
  end

  always_ff @(posedge clk) begin
    if (rst || frame_done) begin
      count_so_far       <= '0;
      running_min        <= '0;
      running_max        <= '0;
      running_sum        <= '0;
      running_square_sum <= '0;
    end else if (s1_valid) begin
      count_so_far       <= frame_upd.cnt;
      running_min        <= frame_upd.min_val;
      running_max        <= frame_upd.max_val;
      running_sum        <= frame_upd.sum;
      running_square_sum <= frame_upd.sqsum;
    end
  end

  smm_post u_post (
    .clk    (clk),
    .rst    (rst),
    .start  (frame_done),
    .frame  (frame_upd),
    .take   (load_out),
    .status (post_status),
    .result (post_result)
  );

  // output register
  assign load_out = post_status.done && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_reg <= post_result;
    end
  end

  assign sample_count = res_reg.cnt;
  assign min_value    = res_reg.min_val;
  assign max_value    = res_reg.max_val;
  assign mean_value   = res_reg.mean_val;
  assign std_value    = res_reg.std_val;

  // a new result beat only comes from a finished sequencer run
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(post_status.done))
    else $error("result beat without finished sequencer");

  // squaring stage stays empty while the sequencer runs
  assert property (@(posedge clk) disable iff (rst)
    post_status.busy |-> !s1_valid)
    else $error("sample in flight during end-of-frame sequence");

  // a reported frame is ordered: min <= mean <= max, count nonzero
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($signed(min_value) <= $signed(mean_value))
                  && ($signed(mean_value) <= $signed(max_value)))
    else $error("mean outside min / max range");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> sample_count != '0)
    else $error("empty frame reported");

endmodule

`default_nettype wire
